[hw/rtl/rtphp_pkg.sv]
// ----------------------------------------------------------------------------
// RTP header parser package
// Shared types, status codes and helpers for the RTP header and extension
// parser.
// ----------------------------------------------------------------------------
package rtphp_pkg;

  // Default packet size limit in bytes
  localparam int unsigned MAX_PACKET_BYTES_DEF = 2048;

  // Width of absolute extension offsets (header end + 4 + 4 * 65535)
  localparam int unsigned EXT_END_W = 19;

  // Fixed header fields
  localparam logic [1:0]  RTP_VERSION    = 2'd2;
  localparam logic [6:0]  FIXED_HDR_LEN  = 7'd12;
  localparam logic [15:0] PROFILE_ONE_B  = 16'hBEDE;
  localparam logic [11:0] PROFILE_TWO_B  = 12'h100;
  localparam logic [3:0]  ONE_B_STOP_ID  = 4'hF;

  // Result kinds
  localparam logic KIND_ELEMENT = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_NOT_RTP      = 4'd1,
    ST_CSRC_SHORT   = 4'd2,
    ST_EXT_HDR_SHRT = 4'd3,
    ST_EXT_VAL_SHRT = 4'd4,
    ST_PAD_NO_PLD   = 4'd5,
    ST_PAD_ZERO     = 4'd6,
    ST_PAD_TOO_BIG  = 4'd7,
    ST_TOO_LONG     = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    STYLE_NONE    = 2'd0,
    STYLE_ONE_B   = 2'd1,
    STYLE_TWO_B   = 2'd2,
    STYLE_UNKNOWN = 2'd3
  } style_e;

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_SKIP = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  element_id;
    logic [10:0] element_offset;
    logic [7:0]  element_length;
    status_e     status;
    logic [11:0] payload_offset;
    logic [11:0] payload_length;
    logic [7:0]  padding_length;
    logic [3:0]  csrc_count;
    style_e      extension_style;
    logic        final_result;
  } out_t;

  // Results produced by one accepted byte, in delivery order
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } push_t;

  // End of the fixed header plus CSRC list
  function automatic logic [6:0] hdr_end(input logic [3:0] cc);
    return FIXED_HDR_LEN + {1'b0, cc, 2'b00};
  endfunction

  // Extension style from the profile word
  function automatic style_e profile_style(input logic [15:0] prof);
    style_e s;
    if (prof == PROFILE_ONE_B) begin
      s = STYLE_ONE_B;
    end else if (prof[15:4] == PROFILE_TWO_B) begin
      s = STYLE_TWO_B;
    end else begin
      s = STYLE_UNKNOWN;
    end
    return s;
  endfunction

endpackage

[hw/rtl/rtphp_parser.sv]
// ----------------------------------------------------------------------------
// RTP header parser core
// Per-byte header tracking, extension element walk and packet verdict.
// ----------------------------------------------------------------------------
module rtphp_parser #(
  parameter int unsigned MAX_PACKET_BYTES = rtphp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  rtphp_pkg::in_t    in_data_i,
  output rtphp_pkg::push_t  push_o
);

  localparam int unsigned PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned EW = rtphp_pkg::EXT_END_W;

  logic [PW-1:0]         pos_q, pos_d;
  logic [7:0]            fhb_q, fhb_d;
  logic [3:0]            cc_q, cc_d;
  logic [15:0]           prof_q, prof_d;
  logic [15:0]           words_q, words_d;
  logic [EW-1:0]         ext_end_q, ext_end_d;
  rtphp_pkg::phase_e     phase_q, phase_d;
  logic [8:0]            skip_q, skip_d;
  logic [7:0]            pend_q, pend_d;
  logic                  stop_q, stop_d;
  logic                  ovf_q, ovf_d;

  logic [7:0]            b;
  logic [EW-1:0]         pos_x, h, idpos;
  logic [4:0]            one_len;
  rtphp_pkg::style_e     wstyle, vstyle;
  logic                  walk_on, e_vld;
  rtphp_pkg::out_t       elem, verd;
  logic [EW-1:0]         lenx, hv, poff, plen;
  rtphp_pkg::status_e    st;
  logic [7:0]            pad;
  logic [3:0]            vcc;

  assign b       = in_data_i.data_byte;
  assign pos_x   = EW'(pos_q);
  assign h       = EW'(rtphp_pkg::hdr_end(cc_q));
  assign idpos   = pos_x - EW'(1);
  assign one_len = {1'b0, b[3:0]} + 5'd1;
  assign wstyle  = rtphp_pkg::profile_style(prof_q);

  // Walk is live inside the extension body of a version 2 packet with X set
  assign walk_on = (fhb_q[7:6] == rtphp_pkg::RTP_VERSION) && fhb_q[4] &&
                   ((wstyle == rtphp_pkg::STYLE_ONE_B) ||
                    (wstyle == rtphp_pkg::STYLE_TWO_B)) &&
                   !stop_q && (pos_x >= h + EW'(4)) && (pos_x < ext_end_q);

  // Advance parser state and build results
  always_comb begin
    pos_d     = pos_q;
    fhb_d     = fhb_q;
    cc_d      = cc_q;
    prof_d    = prof_q;
    words_d   = words_q;
    ext_end_d = ext_end_q;
    phase_d   = phase_q;
    skip_d    = skip_q;
    pend_d    = pend_q;
    stop_d    = stop_q;
    ovf_d     = ovf_q;
    e_vld     = 1'b0;
    elem      = '0;

    elem.result_kind     = rtphp_pkg::KIND_ELEMENT;
    elem.status          = rtphp_pkg::ST_OK;
    elem.csrc_count      = cc_q;
    elem.extension_style = wstyle;
    elem.final_result    = !in_data_i.last_byte;

    if (accept_i) begin
      if (pos_q >= PW'(MAX_PACKET_BYTES)) begin
        ovf_d = 1'b1;
      end else begin
        if (pos_q == '0) begin
          fhb_d = b;
          cc_d  = b[3:0];
        end else begin
          // Capture extension header words
          if (pos_x == h) begin
            prof_d = {b, 8'h00};
          end else if (pos_x == h + EW'(1)) begin
            prof_d = prof_q | {8'h00, b};
          end else if (pos_x == h + EW'(2)) begin
            words_d = {b, 8'h00};
          end else if (pos_x == h + EW'(3)) begin
            words_d   = words_q | {8'h00, b};
            ext_end_d = h + EW'(4) + EW'({words_d, 2'b00});
          end

          // Walk extension elements
          if (walk_on) begin
            case (phase_q)
              rtphp_pkg::PH_SKIP: begin
                if (skip_q != '0) begin
                  skip_d = skip_q - 9'd1;
                end
                if (skip_d == '0) begin
                  phase_d = rtphp_pkg::PH_ID;
                end
              end
              rtphp_pkg::PH_LEN: begin
                if (pos_x + EW'(1) + EW'(b) > ext_end_q) begin
                  stop_d = 1'b1;
                end else begin
                  e_vld               = 1'b1;
                  elem.element_id     = pend_q;
                  elem.element_offset = idpos[10:0];
                  elem.element_length = b;
                  skip_d  = {1'b0, b};
                  phase_d = (b == 8'd0) ? rtphp_pkg::PH_ID : rtphp_pkg::PH_SKIP;
                end
              end
              default: begin
                if (wstyle == rtphp_pkg::STYLE_ONE_B) begin
                  if (b[7:4] == rtphp_pkg::ONE_B_STOP_ID) begin
                    stop_d = 1'b1;
                  end else if (b[7:4] != 4'd0) begin
                    if (pos_x + EW'(1) + EW'(one_len) > ext_end_q) begin
                      stop_d = 1'b1;
                    end else begin
                      e_vld               = 1'b1;
                      elem.element_id     = {4'd0, b[7:4]};
                      elem.element_offset = pos_x[10:0];
                      elem.element_length = {3'd0, one_len};
                      skip_d  = {4'd0, one_len};
                      phase_d = rtphp_pkg::PH_SKIP;
                    end
                  end
                end else begin
                  if (pos_x + EW'(1) >= ext_end_q) begin
                    stop_d = 1'b1;
                  end else if (b != 8'd0) begin
                    pend_d  = b;
                    phase_d = rtphp_pkg::PH_LEN;
                  end
                end
              end
            endcase
          end
        end
        pos_d = pos_q + PW'(1);
      end
    end

    // Packet verdict from the updated state
    lenx   = EW'(pos_d);
    hv     = EW'(rtphp_pkg::hdr_end(cc_d));
    vstyle = rtphp_pkg::STYLE_NONE;
    if ((fhb_d[7:6] == rtphp_pkg::RTP_VERSION) && fhb_d[4] && (lenx >= hv + EW'(4))) begin
      vstyle = rtphp_pkg::profile_style(prof_d);
    end
    st   = rtphp_pkg::ST_OK;
    poff = '0;
    plen = '0;
    pad  = '0;
    vcc  = cc_d;
    if (ovf_d) begin
      st = rtphp_pkg::ST_TOO_LONG;
    end else if ((lenx < EW'(rtphp_pkg::FIXED_HDR_LEN)) ||
                 (fhb_d[7:6] != rtphp_pkg::RTP_VERSION)) begin
      st = rtphp_pkg::ST_NOT_RTP;
    end else if (lenx < hv) begin
      st = rtphp_pkg::ST_CSRC_SHORT;
    end else begin
      poff = hv;
      if (fhb_d[4]) begin
        if (lenx < hv + EW'(4)) begin
          st = rtphp_pkg::ST_EXT_HDR_SHRT;
        end else if (lenx < ext_end_d) begin
          st = rtphp_pkg::ST_EXT_VAL_SHRT;
        end else begin
          poff = ext_end_d;
        end
      end
      if (st == rtphp_pkg::ST_OK) begin
        plen = lenx - poff;
        if (fhb_d[5]) begin
          if (plen == '0) begin
            st = rtphp_pkg::ST_PAD_NO_PLD;
          end else if (b == 8'd0) begin
            st = rtphp_pkg::ST_PAD_ZERO;
          end else if (plen < EW'(b)) begin
            st = rtphp_pkg::ST_PAD_TOO_BIG;
          end else begin
            pad  = b;
            plen = plen - EW'(b);
          end
        end
      end
    end
    if (st != rtphp_pkg::ST_OK) begin
      poff = '0;
      plen = '0;
      pad  = '0;
    end
    if (st == rtphp_pkg::ST_NOT_RTP) begin
      vcc    = '0;
      vstyle = rtphp_pkg::STYLE_NONE;
    end

    verd                 = '0;
    verd.result_kind     = rtphp_pkg::KIND_VERDICT;
    verd.status          = st;
    verd.payload_offset  = poff[11:0];
    verd.payload_length  = plen[11:0];
    verd.padding_length  = pad;
    verd.csrc_count      = vcc;
    verd.extension_style = vstyle;
    verd.final_result    = 1'b1;

    // Return to reset after the last byte
    if (accept_i && in_data_i.last_byte) begin
      pos_d     = '0;
      fhb_d     = '0;
      cc_d      = '0;
      prof_d    = '0;
      words_d   = '0;
      ext_end_d = '0;
      phase_d   = rtphp_pkg::PH_ID;
      skip_d    = '0;
      pend_d    = '0;
      stop_d    = 1'b0;
      ovf_d     = 1'b0;
    end
  end

  // Hand results to the output queue
  always_comb begin
    push_o.count  = {1'b0, e_vld} + {1'b0, accept_i & in_data_i.last_byte};
    push_o.first  = e_vld ? elem : verd;
    push_o.second = verd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      fhb_q     <= '0;
      cc_q      <= '0;
      prof_q    <= '0;
      words_q   <= '0;
      ext_end_q <= '0;
      phase_q   <= rtphp_pkg::PH_ID;
      skip_q    <= '0;
      pend_q    <= '0;
      stop_q    <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      fhb_q     <= fhb_d;
      cc_q      <= cc_d;
      prof_q    <= prof_d;
      words_q   <= words_d;
      ext_end_q <= ext_end_d;
      phase_q   <= phase_d;
      skip_q    <= skip_d;
      pend_q    <= pend_d;
      stop_q    <= stop_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

[hw/rtl/rtphp_out_queue.sv]
// ----------------------------------------------------------------------------
// RTP header parser result queue
// Three-slot result register queue; takes up to two results per cycle and
// delivers one per output transaction.
// ----------------------------------------------------------------------------
module rtphp_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rtphp_pkg::push_t  push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rtphp_pkg::out_t   out_data_o
);

  localparam int unsigned DEPTH = 3;

  rtphp_pkg::out_t slot_q [DEPTH];
  rtphp_pkg::out_t slot_d [DEPTH];
  logic [1:0]      cnt_q, cnt_d;
  logic            pop;
  logic [1:0]      base;
  logic [2:0]      base1;

  assign pop         = out_valid_o & out_ready_i;
  assign base        = cnt_q - {1'b0, pop};
  assign base1       = {1'b0, base} + 3'd1;
  assign cnt_d       = base + push_i.count;
  assign room_o      = (cnt_q <= 2'd1);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot_q[0];

  // Shift out the delivered result, append new ones behind the rest
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_d[i] = slot_q[i];
    end
    if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        slot_d[i] = slot_q[i+1];
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if ((push_i.count != 2'd0) && (2'(i) == base)) begin
        slot_d[i] = push_i.first;
      end
      if ((push_i.count == 2'd2) && (3'(i) == base1)) begin
        slot_d[i] = push_i.second;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

[hw/rtl/rtp_header_and_extension_parser_top.sv]
// ----------------------------------------------------------------------------
// RTP header and extension parser
// Parses one RTP packet byte per transaction, reports extension elements
// and one verdict per packet.
// ----------------------------------------------------------------------------
// Results: each result is registered in the result queue before it is offered.
// Throughput: one byte per cycle while the result queue has room; a byte that reports an
//   element and ends the packet gives two results, delivered one per output transaction.
// Input ready drops while the queue holds two or more results.
// Reset: all parser state clears at once and the queue empties; no sweep.
module rtp_header_and_extension_parser_top #(
  parameter int unsigned MAX_PACKET_BYTES = rtphp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rtphp_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rtphp_pkg::out_t  out_data_o
);

  rtphp_pkg::push_t push;
  logic             accept;

  assign accept = in_valid_i & in_ready_o;

  // Parse bytes
  rtphp_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_data_i(in_data_i),
    .push_o   (push)
  );

  // Queue results
  rtphp_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

[hw/rtl/rtphp_checker.sv]
// ----------------------------------------------------------------------------
// RTP header parser checker
// Port-level checks on the parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rtphp_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input rtphp_pkg::in_t   in_data_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input rtphp_pkg::out_t  out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Offer a result after the last byte of a packet
  a_verdict_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_byte |=> out_valid_o)
    else $error("no result after last byte");

  // Close every verdict, with a status in range
  a_verdict_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind == rtphp_pkg::KIND_VERDICT) |->
      out_data_o.final_result && (out_data_o.status <= rtphp_pkg::ST_TOO_LONG))
    else $error("bad verdict");

  // Keep element results at status OK with zero payload fields and a nonzero id
  a_element_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind == rtphp_pkg::KIND_ELEMENT) |->
      (out_data_o.status == rtphp_pkg::ST_OK) && (out_data_o.payload_offset == '0) &&
      (out_data_o.payload_length == '0) && (out_data_o.element_id != '0))
    else $error("bad element result");

endmodule

bind rtp_header_and_extension_parser_top rtphp_checker u_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP header and extension parser testbench
// Feeds RTP packets one byte per transaction and predicts every element
// report and packet verdict in step with the accepted bytes. Checks each
// output transaction in order against the prediction. The stimulus is a few
// hand-built packets, then mostly well-formed packets with random content,
// some damaged.
// ----------------------------------------------------------------------------
module tb_top;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  rtphp_pkg::in_t    in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  rtphp_pkg::out_t   out_data_o;

  // Stimulus and prediction stores
  rtphp_pkg::in_t    wire_bytes[$];
  logic [7:0]        pkt_bytes[$];
  rtphp_pkg::out_t   parser_reports[$];
  rtphp_pkg::out_t   byte_reports[$];

  int unsigned bytes_sent = 0;
  int unsigned bytes_taken = 0;
  int unsigned err_cnt = 0;
  logic [31:0] cycle_cnt = '0;
  logic        live = 1'b0;
  logic        in_taken = 1'b0;
  logic        quiet_tail = 1'b0;

  // Packet body builder state
  int unsigned body_idx, body_budget, body_cap;

  // Parser shadow state
  int unsigned         pkt_pos;
  logic [7:0]          hdr_byte0;
  int unsigned         csrc_n;
  logic [15:0]         ext_profile;
  logic [15:0]         ext_word_cnt;
  int unsigned         ext_limit;
  rtphp_pkg::phase_e   elem_phase;
  int unsigned         value_left;
  int unsigned         two_b_id;
  logic                walk_done;
  logic                too_long;

  rtp_header_and_extension_parser_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow parser
  // ---------------------------------------------------------------------------
  function automatic void clear_state();
    pkt_pos      = 0;
    hdr_byte0    = '0;
    csrc_n       = 0;
    ext_profile  = '0;
    ext_word_cnt = '0;
    ext_limit    = 0;
    elem_phase   = rtphp_pkg::PH_ID;
    value_left   = 0;
    two_b_id     = 0;
    walk_done    = 1'b0;
    too_long     = 1'b0;
  endfunction

  function automatic int unsigned csrc_end();
    return 32'(rtphp_pkg::FIXED_HDR_LEN) + 4 * csrc_n;
  endfunction

  // Style as known once 'seen' bytes of the packet are in
  function automatic rtphp_pkg::style_e ext_kind(input int unsigned seen);
    if (hdr_byte0[7:6] != rtphp_pkg::RTP_VERSION || !hdr_byte0[4]) begin
      return rtphp_pkg::STYLE_NONE;
    end
    if (seen < csrc_end() + 4) return rtphp_pkg::STYLE_NONE;
    if (ext_profile == rtphp_pkg::PROFILE_ONE_B) return rtphp_pkg::STYLE_ONE_B;
    if (ext_profile[15:4] == rtphp_pkg::PROFILE_TWO_B) return rtphp_pkg::STYLE_TWO_B;
    return rtphp_pkg::STYLE_UNKNOWN;
  endfunction

  function automatic rtphp_pkg::out_t element_report(input int unsigned id,
                                                     input int unsigned off,
                                                     input int unsigned len,
                                                     input rtphp_pkg::style_e sty);
    rtphp_pkg::out_t r;
    r = '0;
    r.result_kind     = rtphp_pkg::KIND_ELEMENT;
    r.element_id      = id[7:0];
    r.element_offset  = off[10:0];
    r.element_length  = len[7:0];
    r.status          = rtphp_pkg::ST_OK;
    r.csrc_count      = csrc_n[3:0];
    r.extension_style = sty;
    return r;
  endfunction

  function automatic rtphp_pkg::out_t verdict_report(input int unsigned bv);
    rtphp_pkg::out_t    r;
    int unsigned        n, h, poff, plen, pad;
    rtphp_pkg::status_e st;
    rtphp_pkg::style_e  sty;
    int unsigned        cc;
    n    = pkt_pos;
    h    = csrc_end();
    st   = rtphp_pkg::ST_OK;
    poff = 0;
    plen = 0;
    pad  = 0;
    cc   = csrc_n;
    sty  = ext_kind(n);
    if (too_long) begin
      st = rtphp_pkg::ST_TOO_LONG;
    end else if (n < 32'(rtphp_pkg::FIXED_HDR_LEN) ||
                 hdr_byte0[7:6] != rtphp_pkg::RTP_VERSION) begin
      st = rtphp_pkg::ST_NOT_RTP;
    end else if (n < h) begin
      st = rtphp_pkg::ST_CSRC_SHORT;
    end else begin
      poff = h;
      if (hdr_byte0[4]) begin
        if (n < h + 4) st = rtphp_pkg::ST_EXT_HDR_SHRT;
        else if (n < ext_limit) st = rtphp_pkg::ST_EXT_VAL_SHRT;
        else poff = ext_limit;
      end
      if (st == rtphp_pkg::ST_OK) begin
        plen = n - poff;
        // padding count sits in the last byte
        if (hdr_byte0[5]) begin
          if (plen == 0) st = rtphp_pkg::ST_PAD_NO_PLD;
          else if (bv == 0) st = rtphp_pkg::ST_PAD_ZERO;
          else if (plen < bv) st = rtphp_pkg::ST_PAD_TOO_BIG;
          else begin
            pad  = bv;
            plen = plen - bv;
          end
        end
      end
    end
    if (st != rtphp_pkg::ST_OK) begin
      poff = 0;
      plen = 0;
      pad  = 0;
    end
    if (st == rtphp_pkg::ST_NOT_RTP) begin
      cc  = 0;
      sty = rtphp_pkg::STYLE_NONE;
    end
    r = '0;
    r.result_kind     = rtphp_pkg::KIND_VERDICT;
    r.status          = st;
    r.payload_offset  = poff[11:0];
    r.payload_length  = plen[11:0];
    r.padding_length  = pad[7:0];
    r.csrc_count      = cc[3:0];
    r.extension_style = sty;
    return r;
  endfunction

  // Advance the element walk by one extension byte
  function automatic void walk_byte(input int unsigned p, input int unsigned bv);
    rtphp_pkg::style_e sty;
    int unsigned       len;
    sty = ext_kind(p + 1);
    if (sty != rtphp_pkg::STYLE_ONE_B && sty != rtphp_pkg::STYLE_TWO_B) return;
    if (walk_done || p < csrc_end() + 4 || p >= ext_limit) return;
    if (elem_phase == rtphp_pkg::PH_SKIP) begin
      if (value_left > 0) value_left = value_left - 1;
      if (value_left == 0) elem_phase = rtphp_pkg::PH_ID;
    end else if (elem_phase == rtphp_pkg::PH_LEN) begin
      // length byte of a two-byte element; drop it if it runs past the end
      if (p + 1 + bv > ext_limit) begin
        walk_done = 1'b1;
      end else begin
        byte_reports.insert(byte_reports.size(),
                            element_report(two_b_id, p - 1, bv, sty));
        value_left = bv;
        elem_phase = (bv == 0) ? rtphp_pkg::PH_ID : rtphp_pkg::PH_SKIP;
      end
    end else if (sty == rtphp_pkg::STYLE_ONE_B) begin
      len = (bv & 32'h0F) + 1;
      if ((bv >> 4) == 32'(rtphp_pkg::ONE_B_STOP_ID)) begin
        walk_done = 1'b1;
      end else if ((bv >> 4) != 0) begin
        if (p + 1 + len > ext_limit) begin
          walk_done = 1'b1;
        end else begin
          byte_reports.insert(byte_reports.size(),
                              element_report(bv >> 4, p, len, sty));
          value_left = len;
          elem_phase = rtphp_pkg::PH_SKIP;
        end
      end
    end else if (p + 1 >= ext_limit) begin
      // two-byte id with no room for its length
      walk_done = 1'b1;
    end else if (bv != 0) begin
      two_b_id   = bv;
      elem_phase = rtphp_pkg::PH_LEN;
    end
  endfunction

  // Work out the reports caused by one accepted byte
  function automatic void parse_byte(input rtphp_pkg::in_t it);
    int unsigned     p, h, bv;
    rtphp_pkg::out_t tail_r;
    byte_reports.delete();
    p  = pkt_pos;
    bv = 32'(it.data_byte);
    if (p >= rtphp_pkg::MAX_PACKET_BYTES_DEF) begin
      too_long = 1'b1;
    end else begin
      if (p == 0) begin
        hdr_byte0 = it.data_byte;
        csrc_n    = bv & 32'h0F;
      end else begin
        h = csrc_end();
        if (p == h) begin
          ext_profile = {it.data_byte, 8'h00};
        end else if (p == h + 1) begin
          ext_profile[7:0] = it.data_byte;
        end else if (p == h + 2) begin
          ext_word_cnt = {it.data_byte, 8'h00};
        end else if (p == h + 3) begin
          ext_word_cnt[7:0] = it.data_byte;
          ext_limit = h + 4 + 4 * 32'(ext_word_cnt);
        end
        walk_byte(p, bv);
      end
      pkt_pos = p + 1;
    end
    if (it.last_byte) begin
      byte_reports.insert(byte_reports.size(), verdict_report(bv));
      clear_state();
    end
    if (byte_reports.size() > 0) begin
      tail_r = byte_reports[byte_reports.size() - 1];
      tail_r.final_result = 1'b1;
      byte_reports[byte_reports.size() - 1] = tail_r;
    end
    foreach (byte_reports[i]) parser_reports.insert(parser_reports.size(), byte_reports[i]);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      err_cnt++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge
  // ---------------------------------------------------------------------------
  initial clear_state();

  always @(posedge clk_i) begin
    rtphp_pkg::out_t want;
    live      <= rst_ni;
    cycle_cnt <= cycle_cnt + 1;
    in_taken  <= in_valid_i && in_ready_o;
    if (out_valid_o && out_ready_i) begin
      if (parser_reports.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 40) $error("report with nothing outstanding, kind %0d",
                                  out_data_o.result_kind);
      end else begin
        want = parser_reports.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(out_data_o.result_kind));
        check_field("element_id", 32'(want.element_id), 32'(out_data_o.element_id));
        check_field("element_offset", 32'(want.element_offset),
                    32'(out_data_o.element_offset));
        check_field("element_length", 32'(want.element_length),
                    32'(out_data_o.element_length));
        check_field("status", 32'(want.status), 32'(out_data_o.status));
        check_field("payload_offset", 32'(want.payload_offset),
                    32'(out_data_o.payload_offset));
        check_field("payload_length", 32'(want.payload_length),
                    32'(out_data_o.payload_length));
        check_field("padding_length", 32'(want.padding_length),
                    32'(out_data_o.padding_length));
        check_field("csrc_count", 32'(want.csrc_count), 32'(out_data_o.csrc_count));
        check_field("extension_style", 32'(want.extension_style),
                    32'(out_data_o.extension_style));
        check_field("final_result", 32'(want.final_result), 32'(out_data_o.final_result));
      end
    end
    // predict after the check: a byte's reports pass through the result queue register first
    if (in_valid_i && in_ready_o) begin
      parse_byte(in_data_i);
      bytes_taken++;
    end
  end

  // Idle bursts are off in the tail and while bits 7:6 of the cycle counter are zero
  function automatic bit idle_ok();
    return !quiet_tail && cycle_cnt[7:6] != 2'b00;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer the next byte at the falling edge, hold until accepted
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    rtphp_pkg::in_t nxt;
    logic           go;
    if (live && !(in_valid_i && !in_taken)) begin
      go  = 1'b0;
      nxt = in_data_i;
      if (gap_left > 0) begin
        gap_left--;
      end else if (wire_bytes.size() > 0) begin
        if (idle_ok() && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 14);
        end else begin
          go  = 1'b1;
          nxt = wire_bytes.pop_front();
        end
      end
      in_valid_i <= go;
      in_data_i  <= nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off that backs up the input
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (live) begin
      if (!hold_done && bytes_taken >= 200) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_ok() && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Packet construction
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rnd_byte();
    logic [31:0] v;
    v = $urandom();
    return v[7:0];
  endfunction

  // Append one byte to the packet under construction
  function automatic void append_byte(input logic [7:0] b);
    pkt_bytes.insert(pkt_bytes.size(), b);
  endfunction

  function automatic void put_body(input logic [7:0] b);
    if (body_idx < body_budget && body_idx < body_cap) begin
      append_byte(b);
      body_idx++;
    end
  endfunction

  // Fill the extension body with elements, alignment bytes and one-byte stop markers
  function automatic void fill_elements(input bit two_b);
    int unsigned r, room, len;
    logic [7:0]  v;
    logic [3:0]  id4;
    while (body_idx < body_budget && body_idx < body_cap) begin
      r    = $urandom_range(0, 15);
      room = body_budget - body_idx;
      v    = rnd_byte();
      if (r < 2) begin
        put_body(8'h00);
      end else if (r == 2 && !two_b) begin
        put_body({rtphp_pkg::ONE_B_STOP_ID, v[3:0]});
      end else if (!two_b) begin
        len = $urandom_range(1, 16);
        // r == 3 leaves the length unclamped so the element may overrun
        if (r != 3 && room >= 2 && len > room - 1) len = room - 1;
        id4 = 4'($urandom_range(1, 14));
        put_body({id4, 4'(len - 1)});
        repeat (len) put_body(rnd_byte());
      end else begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        if (r != 3 && room >= 2 && len > room - 2) len = room - 2;
        put_body(8'($urandom_range(1, 255)));
        put_body(len[7:0]);
        repeat (len) put_body(rnd_byte());
      end
    end
  endfunction

  function automatic void build_rtp(input bit padf, input bit extf, input int unsigned cc,
                                    input logic [15:0] prof, input int unsigned words,
                                    input int unsigned cap, input int unsigned tail);
    int unsigned top;
    pkt_bytes.delete();
    append_byte({rtphp_pkg::RTP_VERSION, padf, extf, cc[3:0]});
    repeat (11 + 4 * cc) append_byte(rnd_byte());
    if (extf) begin
      append_byte(prof[15:8]);
      append_byte(prof[7:0]);
      append_byte(words[15:8]);
      append_byte(words[7:0]);
      body_idx    = 0;
      body_budget = 4 * words;
      body_cap    = cap;
      if (prof == rtphp_pkg::PROFILE_ONE_B) begin
        fill_elements(1'b0);
      end else if (prof[15:4] == rtphp_pkg::PROFILE_TWO_B) begin
        fill_elements(1'b1);
      end else begin
        while (body_idx < body_budget && body_idx < body_cap) put_body(rnd_byte());
      end
    end
    repeat (tail) append_byte(rnd_byte());
    if (padf && tail > 0) begin
      top = (tail < 255) ? tail : 255;
      pkt_bytes[pkt_bytes.size() - 1] = 8'($urandom_range(1, top));
    end
  endfunction

  // Queue the packet's bytes, marking the final one
  function automatic void send_packet();
    rtphp_pkg::in_t it;
    foreach (pkt_bytes[i]) begin
      it.data_byte = pkt_bytes[i];
      it.last_byte = (i == pkt_bytes.size() - 1);
      wire_bytes.insert(wire_bytes.size(), it);
    end
    bytes_sent += pkt_bytes.size();
  endfunction

  function automatic void random_packet();
    int unsigned cc, words, cap, r, keep;
    logic [15:0] prof;
    logic [7:0]  b0, v;
    bit          padf, extf;
    cc    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
    extf  = ($urandom_range(0, 3) != 0);
    padf  = ($urandom_range(0, 2) == 0);
    r     = $urandom_range(0, 9);
    if (r < 4) prof = rtphp_pkg::PROFILE_ONE_B;
    else if (r < 8) prof = {rtphp_pkg::PROFILE_TWO_B, 4'($urandom_range(0, 15))};
    else prof = 16'($urandom_range(0, 65535));
    words = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4);
    cap   = (words > 4) ? $urandom_range(0, 16) : 4 * words;
    build_rtp(padf, extf, cc, prof, words, cap, $urandom_range(0, 12));
    // damage some packets: truncate, break the version, or spoil the pad count
    r = $urandom_range(0, 9);
    if (r == 0) begin
      keep = $urandom_range(1, pkt_bytes.size());
      while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
    end else if (r == 1) begin
      v  = rnd_byte();
      b0 = pkt_bytes[0];
      b0[7:6] = (v[1:0] == rtphp_pkg::RTP_VERSION) ? 2'b11 : v[1:0];
      pkt_bytes[0] = b0;
    end else if (r == 2) begin
      pkt_bytes[pkt_bytes.size() - 1] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
    end
    send_packet();
  endfunction

  task automatic wait_drained();
    while (bytes_taken != bytes_sent || parser_reports.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // single byte with version 3
    pkt_bytes.delete();
    append_byte(8'hFF);
    send_packet();
    // two-byte extension whose zero-length element ends on the last byte
    build_rtp(1'b0, 1'b1, 0, {rtphp_pkg::PROFILE_TWO_B, 4'h0}, 1, 0, 0);
    append_byte(8'h00);
    append_byte(8'h00);
    append_byte(8'hFF);
    append_byte(8'h00);
    send_packet();
    // valid version but shorter than the fixed header
    pkt_bytes.delete();
    append_byte(8'h80);
    repeat (3) append_byte(rnd_byte());
    send_packet();
    wait_drained();

    while (bytes_sent < 560) random_packet();

    // pause the sender until every report is back
    wait_drained();

    while (bytes_sent < 950) random_packet();
    while (wire_bytes.size() != 0) @(negedge clk_i);
    quiet_tail = 1'b1;
    while (bytes_sent < 1100) random_packet();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && parser_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #12_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
